>>> design/ring_buffer_deque_assert.svh
// ----------------------------------------------------------------------------
// ring_buffer_deque_assert.svh
// assertion macros used by the deque checker file
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_DEQUE_ASSERT_SVH
`define RING_BUFFER_DEQUE_ASSERT_SVH

// clocked assertion, disabled while reset is high
`define RBD_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ring_buffer_deque assertion failed");

// clocked assertion that also holds during reset
`define RBD_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("ring_buffer_deque assertion failed");

`endif

>>> design/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// types and constants of the ring buffer deque
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int OPCODE_W = 3;
   localparam int ITEM_W   = 32;
   localparam int OFFSET_W = 4;
   localparam int STATUS_W = 2;
   localparam int CAP_W    = 5;

   typedef enum logic [OPCODE_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_FRONT  = 3'd1,
      OP_PEEK       = 3'd2,
      OP_PUSH_FRONT = 3'd3,
      OP_POP_BACK   = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_BOUNDS = 2'd3
   } status_type;

   typedef struct packed {
      status_type       status;
      logic             rd;
      logic [CAP_W-1:0] free;
   } s1_info_type;

endpackage

>>> design/rbd_ram.sv
// ----------------------------------------------------------------------------
// rbd_ram
// single port ram with registered read data
// ----------------------------------------------------------------------------
module rbd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> design/rbd_ctrl.sv
// ----------------------------------------------------------------------------
// rbd_ctrl
// pointer and count state, operation decode, store access and first stage
// ----------------------------------------------------------------------------
module rbd_ctrl
   import rbd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [CAP_W-1:0]         csr_value,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPCODE_W-1:0]      req_opcode,
   input  logic [ITEM_W-1:0]        req_item_value,
   input  logic [OFFSET_W-1:0]      req_offset,
   input  logic                     take,
   output logic                     s1_valid,
   output s1_info_type              s1_info,
   output logic                     ram_we,
   output logic                     ram_re,
   output logic [$clog2(DEPTH)-1:0] ram_addr,
   output logic [DATA_WIDTH-1:0]    ram_wdata
);

   localparam int CAP_RESET = (DEPTH < 16) ? DEPTH : 16;
   localparam int ADDR_W    = $clog2(DEPTH);

   function automatic logic [CAP_W-1:0] wrap_add(input logic [CAP_W-1:0] a,
                                                 input logic [CAP_W-1:0] b,
                                                 input logic [CAP_W-1:0] cap);
      logic [CAP_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, cap}) begin
         s = s - {1'b0, cap};
      end
      return s[CAP_W-1:0];
   endfunction

   logic [CAP_W-1:0] cap_ff;
   logic [CAP_W-1:0] front_ff, front_in;
   logic [CAP_W-1:0] cnt_ff, cnt_in;
   logic             s1_valid_ff;
   s1_info_type      s1_info_ff, s1_info_in;
   logic [CAP_W-1:0] cap_sat;
   logic [CAP_W-1:0] idx;
   logic             accept;
   logic             full;
   logic             empty;
   logic             we_op;
   logic             re_op;
   op_type           op;

   assign req_ready = !s1_valid_ff || take;
   assign accept    = req_valid && req_ready;
   assign full      = (cnt_ff >= cap_ff);
   assign empty     = (cnt_ff == '0);
   assign op        = op_type'(req_opcode);

   always_comb begin
      cap_sat = csr_value;
      if (csr_value == '0) begin
         cap_sat = CAP_W'(1);
      end else if (32'(csr_value) > DEPTH) begin
         cap_sat = CAP_W'(DEPTH);
      end
   end

   always_comb begin
      s1_info_in.status = ST_OK;
      s1_info_in.rd     = 1'b0;
      front_in          = front_ff;
      cnt_in            = cnt_ff;
      idx               = front_ff;
      we_op             = 1'b0;
      re_op             = 1'b0;
      unique case (op)
         OP_PUSH_BACK: begin
            if (full) begin
               s1_info_in.status = ST_FULL;
            end else begin
               idx    = wrap_add(front_ff, cnt_ff, cap_ff);
               we_op  = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               s1_info_in.status = ST_EMPTY;
            end else begin
               re_op         = 1'b1;
               s1_info_in.rd = 1'b1;
               cnt_in        = cnt_ff - 1'b1;
               front_in      = wrap_add(front_ff, CAP_W'(1), cap_ff);
            end
         end
         OP_PEEK: begin
            if (CAP_W'(req_offset) >= cnt_ff) begin
               s1_info_in.status = ST_BOUNDS;
            end else begin
               idx           = wrap_add(front_ff, CAP_W'(req_offset), cap_ff);
               re_op         = 1'b1;
               s1_info_in.rd = 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               s1_info_in.status = ST_FULL;
            end else begin
               idx      = (front_ff == '0) ? cap_ff - 1'b1 : front_ff - 1'b1;
               we_op    = 1'b1;
               front_in = idx;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               s1_info_in.status = ST_EMPTY;
            end else begin
               idx           = wrap_add(front_ff, cnt_ff - 1'b1, cap_ff);
               re_op         = 1'b1;
               s1_info_in.rd = 1'b1;
               cnt_in        = cnt_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
      s1_info_in.free = cap_ff - cnt_in;
   end

   assign ram_we    = accept && we_op;
   assign ram_re    = accept && re_op;
   assign ram_addr  = ADDR_W'(idx);
   assign ram_wdata = DATA_WIDTH'(req_item_value);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= CAP_W'(CAP_RESET);
         front_ff    <= '0;
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            cap_ff   <= cap_sat;
            front_ff <= '0;
            cnt_ff   <= '0;
         end else if (accept) begin
            front_ff <= front_in;
            cnt_ff   <= cnt_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (take) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= s1_info_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_info  = s1_info_ff;

endmodule

>>> design/rbd_resp_stage.sv
// ----------------------------------------------------------------------------
// rbd_resp_stage
// response register, merges store read data with status and free count
// ----------------------------------------------------------------------------
module rbd_resp_stage
   import rbd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  s1_valid,
   input  s1_info_type           s1_info,
   input  logic [DATA_WIDTH-1:0] ram_rdata,
   output logic                  take,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ITEM_W-1:0]     rsp_item_out,
   output logic [CAP_W-1:0]      rsp_free_slots
);

   logic              valid_ff;
   status_type        status_ff;
   logic [ITEM_W-1:0] item_ff, item_in;
   logic [CAP_W-1:0]  free_ff;

   assign take    = !valid_ff || rsp_ready;
   assign item_in = s1_info.rd ? ITEM_W'(ram_rdata) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take && s1_valid) begin
         status_ff <= s1_info.status;
         item_ff   <= item_in;
         free_ff   <= s1_info.free;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_item_out   = item_ff;
   assign rsp_free_slots = free_ff;

endmodule

>>> design/ring_buffer_deque.sv
// ----------------------------------------------------------------------------
// ring_buffer_deque
// circular double ended queue with configurable active capacity
// ----------------------------------------------------------------------------
//   channel   direction   handshake               payload
//   req       in          req_valid / req_ready   opcode, item_value, offset
//   rsp       out         rsp_valid / rsp_ready   status, item_out, free_slots
//   csr       in          csr_valid / csr_ready   active_capacity
//
// one request per cycle sustained while rsp_ready stays high, the response passes
// the registered read port of the slot store and first stage, then the response stage
// reset empties the queue and sets capacity to the smaller of DEPTH and 16
// store content is undefined after reset, no clearing pass
// a stalled response holds both stages, and drops req_ready once the first stage is full
// ----------------------------------------------------------------------------
module ring_buffer_deque
   import rbd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_W-1:0]    csr_active_capacity,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OPCODE_W-1:0] req_opcode,
   input  logic [ITEM_W-1:0]   req_item_value,
   input  logic [OFFSET_W-1:0] req_offset,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ITEM_W-1:0]   rsp_item_out,
   output logic [CAP_W-1:0]    rsp_free_slots
);

   logic                     take;
   logic                     s1_valid;
   s1_info_type              s1_info;
   logic                     ram_we;
   logic                     ram_re;
   logic [$clog2(DEPTH)-1:0] ram_addr;
   logic [DATA_WIDTH-1:0]    ram_wdata;
   logic [DATA_WIDTH-1:0]    ram_rdata;

   assign csr_ready = 1'b1;

   rbd_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_value      (csr_active_capacity),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_item_value (req_item_value),
      .req_offset     (req_offset),
      .take           (take),
      .s1_valid       (s1_valid),
      .s1_info        (s1_info),
      .ram_we         (ram_we),
      .ram_re         (ram_re),
      .ram_addr       (ram_addr),
      .ram_wdata      (ram_wdata)
   );

   rbd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_slot_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   rbd_resp_stage #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_resp (
      .clock          (clock),
      .reset          (reset),
      .s1_valid       (s1_valid),
      .s1_info        (s1_info),
      .ram_rdata      (ram_rdata),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_item_out   (rsp_item_out),
      .rsp_free_slots (rsp_free_slots)
   );

endmodule

>>> design/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker
// port level checks of the ring buffer deque, bound to the top level
// ----------------------------------------------------------------------------
`include "ring_buffer_deque_assert.svh"

module rbd_checker
   import rbd_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ITEM_W-1:0]   rsp_item_out,
   input logic [CAP_W-1:0]    rsp_free_slots
);

   // stalled response keeps its payload
   `RBD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_item_out) && $stable(rsp_free_slots))

   // failed operations return no data
   `RBD_ASSERT(a_fail_no_data, clock, reset, rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_EMPTY || rsp_status == ST_BOUNDS) |-> rsp_item_out == '0)

   // a full status means no free slot
   `RBD_ASSERT(a_full_no_free, clock, reset, rsp_valid && rsp_status == ST_FULL |-> rsp_free_slots == '0)

   // free count never exceeds the store
   `RBD_ASSERT(a_free_bound, clock, reset, rsp_valid |-> 32'(rsp_free_slots) <= DEPTH)

   // no response right after reset
   `RBD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

bind ring_buffer_deque rbd_checker #(.DEPTH(DEPTH)) u_rbd_checker (.*);
